[rtl/stb_pkg.sv]
// ----------------------------------------------------------------------------
// stb_pkg
// Shared sizes, opcodes and the control store of the software timer bank.
// ----------------------------------------------------------------------------
package stb_pkg;

    localparam int TIMER_COUNT = 8;
    localparam int ID_W        = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int OP_W        = 4;
    localparam int SLOT_W      = 8;
    localparam int TIME_W      = 32;
    localparam int STEP_W      = 4;
    localparam int ACT_W       = 3;
    localparam int CND_W       = 3;

    // opcodes
    localparam logic [OP_W-1:0] OP_CREATE_ONESHOT = 4'd0;
    localparam logic [OP_W-1:0] OP_CREATE_REPEAT  = 4'd1;
    localparam logic [OP_W-1:0] OP_START          = 4'd2;
    localparam logic [OP_W-1:0] OP_STOP           = 4'd3;
    localparam logic [OP_W-1:0] OP_RESTART        = 4'd4;
    localparam logic [OP_W-1:0] OP_SET_PERIOD     = 4'd5;
    localparam logic [OP_W-1:0] OP_KILL           = 4'd6;
    localparam logic [OP_W-1:0] OP_QUERY          = 4'd7;
    localparam logic [OP_W-1:0] OP_TICK           = 4'd8;

    // datapath actions
    localparam logic [ACT_W-1:0] ACT_NOP        = 3'd0;
    localparam logic [ACT_W-1:0] ACT_CMD        = 3'd1;
    localparam logic [ACT_W-1:0] ACT_TICK_SLOT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_CLOSE      = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CREATE_TRY = 3'd4;
    localparam logic [ACT_W-1:0] ACT_INC        = 3'd5;
    localparam logic [ACT_W-1:0] ACT_ERROR      = 3'd6;

    // jump conditions
    localparam logic [CND_W-1:0] CND_NEVER    = 3'd0;
    localparam logic [CND_W-1:0] CND_ALWAYS   = 3'd1;
    localparam logic [CND_W-1:0] CND_NO_START = 3'd2;
    localparam logic [CND_W-1:0] CND_TICK     = 3'd3;
    localparam logic [CND_W-1:0] CND_CREATE   = 3'd4;
    localparam logic [CND_W-1:0] CND_FREE     = 3'd5;
    localparam logic [CND_W-1:0] CND_MORE     = 3'd6;

    // program steps
    localparam logic [STEP_W-1:0] ST_IDLE        = 4'd0;
    localparam logic [STEP_W-1:0] ST_DEC_TICK    = 4'd1;
    localparam logic [STEP_W-1:0] ST_DEC_CREATE  = 4'd2;
    localparam logic [STEP_W-1:0] ST_CMD         = 4'd3;
    localparam logic [STEP_W-1:0] ST_TICK_SCAN   = 4'd4;
    localparam logic [STEP_W-1:0] ST_TICK_CLOSE  = 4'd5;
    localparam logic [STEP_W-1:0] ST_CREATE_TRY  = 4'd6;
    localparam logic [STEP_W-1:0] ST_CREATE_NEXT = 4'd7;
    localparam logic [STEP_W-1:0] ST_CREATE_FAIL = 4'd8;

    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic [CND_W-1:0]  cond;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic op_tick;
        logic op_create;
        logic slot_free;
        logic ptr_last;
    } t_dp_status;

    // control store: taken condition jumps to target, else falls through
    function automatic t_ctrl rom_word(input logic [STEP_W-1:0] step);
        t_ctrl w;
        unique case (step)
            ST_IDLE:        w = '{ACT_NOP,        CND_NO_START, ST_IDLE};
            ST_DEC_TICK:    w = '{ACT_NOP,        CND_TICK,     ST_TICK_SCAN};
            ST_DEC_CREATE:  w = '{ACT_NOP,        CND_CREATE,   ST_CREATE_TRY};
            ST_CMD:         w = '{ACT_CMD,        CND_ALWAYS,   ST_IDLE};
            ST_TICK_SCAN:   w = '{ACT_TICK_SLOT,  CND_MORE,     ST_TICK_SCAN};
            ST_TICK_CLOSE:  w = '{ACT_CLOSE,      CND_ALWAYS,   ST_IDLE};
            ST_CREATE_TRY:  w = '{ACT_CREATE_TRY, CND_FREE,     ST_IDLE};
            ST_CREATE_NEXT: w = '{ACT_INC,        CND_MORE,     ST_CREATE_TRY};
            ST_CREATE_FAIL: w = '{ACT_ERROR,      CND_ALWAYS,   ST_IDLE};
            default:        w = '{ACT_NOP,        CND_ALWAYS,   ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

[rtl/stb_sequencer.sv]
// ----------------------------------------------------------------------------
// stb_sequencer
// Step counter over the control store with conditional jumps.
// ----------------------------------------------------------------------------
module stb_sequencer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  stb_pkg::t_dp_status i_status,
    output stb_pkg::t_ctrl     o_ctrl,
    output logic               o_busy
);

    logic [stb_pkg::STEP_W-1:0] r_step;
    logic [stb_pkg::STEP_W-1:0] n_step;
    stb_pkg::t_ctrl             w_ctrl;
    logic                       w_taken;

    assign w_ctrl = stb_pkg::rom_word(r_step);

    always_comb begin
        unique case (w_ctrl.cond)
            stb_pkg::CND_NEVER:    w_taken = 1'b0;
            stb_pkg::CND_ALWAYS:   w_taken = 1'b1;
            stb_pkg::CND_NO_START: w_taken = !i_start;
            stb_pkg::CND_TICK:     w_taken = i_status.op_tick;
            stb_pkg::CND_CREATE:   w_taken = i_status.op_create;
            stb_pkg::CND_FREE:     w_taken = i_status.slot_free;
            stb_pkg::CND_MORE:     w_taken = !i_status.ptr_last;
            default:               w_taken = 1'b1;
        endcase
        n_step = w_taken ? w_ctrl.target : r_step + stb_pkg::STEP_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= stb_pkg::ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl = w_ctrl;
    assign o_busy = (r_step != stb_pkg::ST_IDLE);

endmodule

[rtl/stb_datapath.sv]
// ----------------------------------------------------------------------------
// stb_datapath
// Slot table, latched command beat, scan pointer and result registers.
// ----------------------------------------------------------------------------
module stb_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [stb_pkg::ACT_W-1:0]   i_act,
    input  logic [stb_pkg::OP_W-1:0]    i_opcode,
    input  logic [stb_pkg::SLOT_W-1:0]  i_timer_id,
    input  logic [stb_pkg::TIME_W-1:0]  i_period_ms,
    input  logic [stb_pkg::TIME_W-1:0]  i_now_ms,
    input  logic                        i_notify_enable,
    output stb_pkg::t_dp_status         o_status_bus,
    output logic                        o_result_valid,
    output logic                        o_status,
    output logic [stb_pkg::SLOT_W-1:0]  o_slot_id,
    output logic                        o_is_running,
    output logic                        o_fired,
    output logic                        o_last
);

    localparam int N = stb_pkg::TIMER_COUNT;

    logic [N-1:0]                r_used, r_running, r_repeat, r_notify;
    logic [N-1:0]                n_used, n_running, n_repeat, n_notify;
    logic [stb_pkg::TIME_W-1:0]  r_period [N];
    logic [stb_pkg::TIME_W-1:0]  n_period [N];
    logic [stb_pkg::TIME_W-1:0]  r_start_t [N];
    logic [stb_pkg::TIME_W-1:0]  n_start_t [N];

    logic [stb_pkg::OP_W-1:0]    r_op;
    logic [stb_pkg::SLOT_W-1:0]  r_id;
    logic [stb_pkg::TIME_W-1:0]  r_per_in, r_now;
    logic                        r_ntf_in;
    logic [stb_pkg::ID_W-1:0]    r_ptr, n_ptr;

    logic                        r_rv, n_rv, r_st, n_st, r_run_o, n_run_o;
    logic                        r_fire_o, n_fire_o, r_last_o, n_last_o;
    logic [stb_pkg::SLOT_W-1:0]  r_slot_o, n_slot_o;

    logic                        w_id_ok, w_valid, w_hit;
    logic [stb_pkg::ID_W-1:0]    w_idx;
    logic [stb_pkg::TIME_W-1:0]  w_elapsed;

    assign w_id_ok   = (r_id < stb_pkg::SLOT_W'(N));
    assign w_idx     = r_id[stb_pkg::ID_W-1:0];
    assign w_valid   = w_id_ok && r_used[w_idx];
    // elapsed time wraps modulo 2^32
    assign w_elapsed = r_now - r_start_t[r_ptr];
    assign w_hit     = r_used[r_ptr] && r_running[r_ptr] && (w_elapsed >= r_period[r_ptr]);

    assign o_status_bus.op_tick   = (r_op == stb_pkg::OP_TICK);
    assign o_status_bus.op_create = (r_op == stb_pkg::OP_CREATE_ONESHOT) ||
                                    (r_op == stb_pkg::OP_CREATE_REPEAT);
    assign o_status_bus.slot_free = !r_used[r_ptr];
    assign o_status_bus.ptr_last  = (r_ptr == stb_pkg::ID_W'(N - 1));

    always_comb begin
        n_used    = r_used;
        n_running = r_running;
        n_repeat  = r_repeat;
        n_notify  = r_notify;
        n_period  = r_period;
        n_start_t = r_start_t;
        n_ptr     = r_ptr;
        n_rv      = 1'b0;
        n_st      = 1'b0;
        n_slot_o  = '0;
        n_run_o   = 1'b0;
        n_fire_o  = 1'b0;
        n_last_o  = 1'b0;
        if (i_accept) begin
            n_ptr = '0;
        end
        case (i_act)
            stb_pkg::ACT_CMD: begin
                n_rv     = 1'b1;
                n_last_o = 1'b1;
                n_st     = !w_valid;
                case (r_op)
                    stb_pkg::OP_START: begin
                        if (w_valid && !r_running[w_idx]) begin
                            n_running[w_idx] = 1'b1;
                            n_start_t[w_idx] = r_now;
                        end
                    end
                    stb_pkg::OP_STOP: begin
                        if (w_valid) n_running[w_idx] = 1'b0;
                    end
                    stb_pkg::OP_RESTART: begin
                        if (w_valid) begin
                            n_running[w_idx] = 1'b1;
                            n_start_t[w_idx] = r_now;
                        end
                    end
                    stb_pkg::OP_SET_PERIOD: begin
                        if (w_valid) n_period[w_idx] = r_per_in;
                    end
                    stb_pkg::OP_KILL: begin
                        // unused slots may be killed too
                        n_st = !w_id_ok;
                        if (w_id_ok) begin
                            n_used[w_idx]    = 1'b0;
                            n_running[w_idx] = 1'b0;
                        end
                    end
                    stb_pkg::OP_QUERY: begin
                        n_run_o = w_valid && r_running[w_idx];
                    end
                    default: n_st = 1'b1;
                endcase
            end
            stb_pkg::ACT_TICK_SLOT: begin
                if (w_hit) begin
                    if (r_repeat[r_ptr]) n_start_t[r_ptr] = r_now;
                    else                 n_running[r_ptr] = 1'b0;
                    if (r_notify[r_ptr]) begin
                        n_rv     = 1'b1;
                        n_fire_o = 1'b1;
                        n_slot_o = stb_pkg::SLOT_W'(r_ptr);
                    end
                end
                n_ptr = r_ptr + stb_pkg::ID_W'(1);
            end
            stb_pkg::ACT_CLOSE: begin
                n_rv     = 1'b1;
                n_last_o = 1'b1;
            end
            stb_pkg::ACT_CREATE_TRY: begin
                if (!r_used[r_ptr]) begin
                    n_used[r_ptr]    = 1'b1;
                    n_running[r_ptr] = 1'b0;
                    n_repeat[r_ptr]  = (r_op == stb_pkg::OP_CREATE_REPEAT);
                    n_notify[r_ptr]  = r_ntf_in;
                    n_period[r_ptr]  = r_per_in;
                    n_start_t[r_ptr] = '0;
                    n_rv             = 1'b1;
                    n_last_o         = 1'b1;
                    n_slot_o         = stb_pkg::SLOT_W'(r_ptr);
                end
            end
            stb_pkg::ACT_INC: n_ptr = r_ptr + stb_pkg::ID_W'(1);
            stb_pkg::ACT_ERROR: begin
                n_rv     = 1'b1;
                n_st     = 1'b1;
                n_last_o = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_running <= '0;
            r_repeat  <= '0;
            r_notify  <= '0;
            r_ptr     <= '0;
            r_rv      <= 1'b0;
        end else begin
            r_used    <= n_used;
            r_running <= n_running;
            r_repeat  <= n_repeat;
            r_notify  <= n_notify;
            r_ptr     <= n_ptr;
            r_rv      <= n_rv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_period  <= n_period;
        r_start_t <= n_start_t;
        r_st      <= n_st;
        r_slot_o  <= n_slot_o;
        r_run_o   <= n_run_o;
        r_fire_o  <= n_fire_o;
        r_last_o  <= n_last_o;
        if (i_accept) begin
            r_op     <= i_opcode;
            r_id     <= i_timer_id;
            r_per_in <= i_period_ms;
            r_now    <= i_now_ms;
            r_ntf_in <= i_notify_enable;
        end
    end

    assign o_result_valid = r_rv;
    assign o_status       = r_st;
    assign o_slot_id      = r_slot_o;
    assign o_is_running   = r_run_o;
    assign o_fired        = r_fire_o;
    assign o_last         = r_last_o;

endmodule

[rtl/software_timer_bank_unit.sv]
// ----------------------------------------------------------------------------
// software_timer_bank_unit
// Bank of software timers driven by one opcode beat at a time.
// ----------------------------------------------------------------------------
// A command beat is taken when i_start is high and o_busy is low. Each result
// shows for one cycle with o_result_valid high and cannot be held off; the
// final result of a beat has o_last set. A slot command (start, stop,
// restart, set period, kill, query) passes the tick and create decode steps
// to the command step, whose result is registered. A create walks the slots
// in order, trying each and stepping past it while it is occupied, and ends
// on the first free slot or with an error result after the last. A tick
// visits every slot in one cycle each, giving fire reports as it goes, then
// closes. These steps come from the step program of the sequencer; o_busy
// drops on the cycle the final result shows; the next beat can be taken then.
module software_timer_bank_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [stb_pkg::OP_W-1:0]    i_opcode,
    input  logic [stb_pkg::SLOT_W-1:0]  i_timer_id,
    input  logic [stb_pkg::TIME_W-1:0]  i_period_ms,
    input  logic [stb_pkg::TIME_W-1:0]  i_now_ms,
    input  logic                        i_notify_enable,
    output logic                        o_busy,
    output logic                        o_result_valid,
    output logic                        o_status,
    output logic [stb_pkg::SLOT_W-1:0]  o_slot_id,
    output logic                        o_is_running,
    output logic                        o_fired,
    output logic                        o_last
);

    stb_pkg::t_ctrl      w_ctrl;
    stb_pkg::t_dp_status w_status;
    logic                w_accept;

    assign w_accept = i_start && !o_busy;

    stb_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (w_status),
        .o_ctrl   (w_ctrl),
        .o_busy   (o_busy)
    );

    stb_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_act           (w_ctrl.act),
        .i_opcode        (i_opcode),
        .i_timer_id      (i_timer_id),
        .i_period_ms     (i_period_ms),
        .i_now_ms        (i_now_ms),
        .i_notify_enable (i_notify_enable),
        .o_status_bus    (w_status),
        .o_result_valid  (o_result_valid),
        .o_status        (o_status),
        .o_slot_id       (o_slot_id),
        .o_is_running    (o_is_running),
        .o_fired         (o_fired),
        .o_last          (o_last)
    );

`ifndef SYNTHESIS
    // a beat that is not the final one is always a fire report
    a_mid_is_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_last |-> o_fired)
        else $error("non-final result without fired");

    a_fire_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_fired |-> !o_status && !o_is_running && !o_last)
        else $error("fire report with stray fields");

    // more results still to come keeps the bank busy
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_last |-> o_busy)
        else $error("idle while a beat is unfinished");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_busy)
        else $error("accepted beat did not start the program");
`endif

endmodule
